// File: rtl/core/lms_pkg.sv
// Package for the list marker scanner: character class bundle, marker codes
// and the shared counter limits. No dependencies.
`default_nettype none

package lms_pkg;

    // Marker codes as reported on the result word
    localparam logic [2:0] MK_DASH  = 3'd0;
    localparam logic [2:0] MK_STAR  = 3'd1;
    localparam logic [2:0] MK_PLUS  = 3'd2;
    localparam logic [2:0] MK_DOT   = 3'd3;
    localparam logic [2:0] MK_PAREN = 3'd4;

    // Position counters saturate here
    localparam logic [3:0] CNT_MAX = 4'd15;
    // Padding wider than this falls back to a single column
    localparam logic [3:0] INDENT_LIMIT = 4'd4;

    localparam int unsigned NUM_W = 30;
    localparam int unsigned POS_W = 17;
    localparam int unsigned OFF_W = 16;

    // Classification of one text byte
    typedef struct packed {
        logic       bullet;    // '-', '*', '+'
        logic       digit;     // '0'..'9'
        logic       delim;     // '.', ')'
        logic       space;     // space or tab
        logic       tab;
        logic       blank;     // space, tab, LF, CR
        logic [2:0] code;      // marker code for bullet or delim
        logic [3:0] digit_val;
    } char_class_t;

endpackage

`default_nettype wire

// File: rtl/core/lms_classify.sv
// Byte classifier for the list marker scanner.
// Depends on lms_pkg for the class bundle and marker codes.
`default_nettype none

module lms_classify (
    input  wire logic [7:0]          character,
    output lms_pkg::char_class_t     cls
);

    always_comb
    begin
        cls           = '0;
        cls.digit_val = character[3:0];
        cls.digit     = (character >= 8'h30) && (character <= 8'h39);
        cls.tab       = (character == 8'h09);
        cls.space     = (character == 8'h20) || cls.tab;
        cls.blank     = cls.space || (character == 8'h0A) || (character == 8'h0D);
        case (character)
            8'h2D:
            begin
                cls.bullet = 1'b1;
                cls.code   = lms_pkg::MK_DASH;
            end
            8'h2A:
            begin
                cls.bullet = 1'b1;
                cls.code   = lms_pkg::MK_STAR;
            end
            8'h2B:
            begin
                cls.bullet = 1'b1;
                cls.code   = lms_pkg::MK_PLUS;
            end
            8'h2E:
            begin
                cls.delim = 1'b1;
                cls.code  = lms_pkg::MK_DOT;
            end
            8'h29:
            begin
                cls.delim = 1'b1;
                cls.code  = lms_pkg::MK_PAREN;
            end
            default:
            begin
                cls.code = lms_pkg::MK_DASH;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/list_marker_scanner.sv
// Top level of the list marker scanner: stream handshake, line state and
// result register. Depends on lms_pkg and lms_classify.
`default_nettype none

// list_marker_scanner takes one byte of a text line per input word, starting
// at the scan offset, and on the word flagged tlast returns one result word
// telling whether a Markdown list marker ('-', '*', '+', or up to MAX_DIGITS
// digits then '.' or ')') opens the line, with its code, start number,
// width, content position and padding; a failed match returns all zeros.
// Words without tlast return nothing. The block takes one word every cycle:
// each word passes an input register, one step of classify-and-update logic
// on the line state, and for tlast words a result register, which holds
// the result word while it is valid. Input and result registers decouple
// the sides; input stalls only when a tlast word meets a full, unaccepted
// result register. The line offset is taken from the line's first word
// that carries a character. Tabs advance the padding count to the next
// multiple of TAB_STOP, counted from the marker.

module list_marker_scanner #(
    parameter int unsigned MAX_DIGITS = 9,
    parameter int unsigned TAB_STOP   = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] character, [23:8] line_offset
    input  wire logic        s_tlast,   // end_of_line
    input  wire logic        s_tuser,   // has_char
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [2:0] marker_code, [32:3] list_start,
                                        // [36:33] lead_width,
                                        // [53:37] content_position,
                                        // [56:54] padding, [63:57] zero
    output logic [1:0]       m_tuser    // [0] matched, [1] ordered
);

    localparam int unsigned DCW = $clog2(MAX_DIGITS + 1);
    localparam logic [DCW-1:0] DIG_MAX = DCW'(MAX_DIGITS);
    localparam logic [3:0] TAB_W = 4'(TAB_STOP);

    typedef enum logic [2:0] {
        PH_START,
        PH_DIGITS,
        PH_AFTER,
        PH_SPACES,
        PH_TAIL
    } phase_t;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_has_reg;
    logic        in_eol_reg;
    logic [15:0] in_off_reg;

    // line state
    phase_t                        phase_reg,       phase_next;
    logic [DCW-1:0]                dcnt_reg,        dcnt_next;
    logic [lms_pkg::NUM_W-1:0]     num_reg,         num_next;
    logic [2:0]                    kind_reg,        kind_next;
    logic                          ordered_reg,     ordered_next;
    logic [3:0]                    consumed_reg,    consumed_next;
    logic [3:0]                    sp_start_reg,    sp_start_next;
    logic [3:0]                    cols_reg,        cols_next;
    logic                          blank_reg,       blank_next;
    logic                          failed_reg,      failed_next;
    logic [lms_pkg::OFF_W-1:0]     offset_reg,      offset_next;

    // result register
    logic        out_valid_reg;
    logic [63:0] out_data_reg,  out_data_next;
    logic [1:0]  out_user_reg,  out_user_next;

    lms_pkg::char_class_t cls;

    logic        advance;
    logic        out_free;
    logic [3:0]  consumed_inc;
    logic [3:0]  tab_rem;
    logic [3:0]  col_add;
    logic [4:0]  col_sum;
    logic [3:0]  cols_adv;
    logic        cols_over;
    logic [lms_pkg::NUM_W-1:0] num_x10;
    logic        ok;
    logic [3:0]  width;
    logic [2:0]  pad;
    logic [lms_pkg::POS_W-1:0] content_pos;

    lms_classify u_classify (
        .character (in_char_reg),
        .cls       (cls)
    );

    // handshake: a non-final word always moves on; a final one needs the
    // result slot
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_eol_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // column advance for one space or tab, relative to the marker
    always_comb
    begin
        tab_rem = cols_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (tab_rem >= TAB_W)
                tab_rem = tab_rem - TAB_W;
        end
        col_add   = cls.tab ? (TAB_W - tab_rem) : 4'd1;
        col_sum   = {1'b0, cols_reg} + {1'b0, col_add};
        cols_adv  = (col_sum > {1'b0, lms_pkg::CNT_MAX}) ? lms_pkg::CNT_MAX : col_sum[3:0];
        cols_over = cols_adv > lms_pkg::INDENT_LIMIT;
    end

    assign consumed_inc = (consumed_reg == lms_pkg::CNT_MAX) ? lms_pkg::CNT_MAX
                                                             : consumed_reg + 4'd1;
    assign num_x10 = {num_reg[lms_pkg::NUM_W-4:0], 3'b000}
                   + {num_reg[lms_pkg::NUM_W-2:0], 1'b0}
                   + {{(lms_pkg::NUM_W-4){1'b0}}, cls.digit_val};

    // one step of the scan on the registered word
    always_comb
    begin
        phase_next    = phase_reg;
        dcnt_next     = dcnt_reg;
        num_next      = num_reg;
        kind_next     = kind_reg;
        ordered_next  = ordered_reg;
        consumed_next = consumed_reg;
        sp_start_next = sp_start_reg;
        cols_next     = cols_reg;
        blank_next    = blank_reg;
        failed_next   = failed_reg;

        // offset is captured on every word of a line up to its first character
        if (phase_reg == PH_START && !failed_reg && consumed_reg == 4'd0)
            offset_next = in_off_reg;
        else
            offset_next = offset_reg;

        if (in_has_reg && !failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cls.bullet)
                    begin
                        kind_next     = cls.code;
                        ordered_next  = 1'b0;
                        consumed_next = 4'd1;
                        phase_next    = PH_AFTER;
                    end
                    else if (cls.digit)
                    begin
                        num_next      = {{(lms_pkg::NUM_W-4){1'b0}}, cls.digit_val};
                        dcnt_next     = DCW'(1);
                        consumed_next = 4'd1;
                        phase_next    = PH_DIGITS;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (cls.digit && dcnt_reg < DIG_MAX)
                    begin
                        num_next      = num_x10;
                        dcnt_next     = dcnt_reg + DCW'(1);
                        consumed_next = consumed_inc;
                    end
                    else if (cls.delim)
                    begin
                        kind_next     = cls.code;
                        ordered_next  = 1'b1;
                        consumed_next = consumed_inc;
                        phase_next    = PH_AFTER;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_AFTER:
                begin
                    if (cls.space)
                    begin
                        sp_start_next = consumed_reg;
                        cols_next     = cols_adv;
                        consumed_next = consumed_inc;
                        phase_next    = cols_over ? PH_TAIL : PH_SPACES;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_SPACES:
                begin
                    if (cls.space)
                    begin
                        cols_next     = cols_adv;
                        consumed_next = consumed_inc;
                        if (cols_over)
                            phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                        if (!cls.blank)
                            blank_next = 1'b0;
                    end
                end
                default:
                begin
                    if (!cls.blank)
                        blank_next = 1'b0;
                end
            endcase
        end

        // result of the line, from the updated state
        ok = !failed_next && (phase_next == PH_AFTER || phase_next == PH_SPACES ||
                              phase_next == PH_TAIL);
        if (phase_next == PH_AFTER)
        begin
            width = consumed_next;
            pad   = 3'd0;
        end
        else if (blank_next || cols_next > lms_pkg::INDENT_LIMIT)
        begin
            // blank rest or wide spacing: content starts one past the marker
            width = (sp_start_next == lms_pkg::CNT_MAX) ? lms_pkg::CNT_MAX
                                                        : sp_start_next + 4'd1;
            pad   = 3'd1;
        end
        else
        begin
            width = consumed_next;
            pad   = cols_next[2:0];
        end
        content_pos = {1'b0, offset_next} + {{(lms_pkg::POS_W-4){1'b0}}, width};

        if (ok)
        begin
            out_data_next = {7'd0, pad, content_pos, width, num_next, kind_next};
            out_user_next = {ordered_next, 1'b1};
        end
        else
        begin
            out_data_next = '0;
            out_user_next = '0;
        end

        // end of line returns the per-line state to its start values
        if (in_eol_reg)
        begin
            phase_next    = PH_START;
            dcnt_next     = '0;
            num_next      = '0;
            kind_next     = '0;
            ordered_next  = 1'b0;
            consumed_next = '0;
            sp_start_next = '0;
            cols_next     = '0;
            blank_next    = 1'b1;
            failed_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_char_reg   <= '0;
            in_has_reg    <= 1'b0;
            in_eol_reg    <= 1'b0;
            in_off_reg    <= '0;
            phase_reg     <= PH_START;
            dcnt_reg      <= '0;
            num_reg       <= '0;
            kind_reg      <= '0;
            ordered_reg   <= 1'b0;
            consumed_reg  <= '0;
            sp_start_reg  <= '0;
            cols_reg      <= '0;
            blank_reg     <= 1'b1;
            failed_reg    <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_char_reg  <= s_tdata[7:0];
                in_has_reg   <= s_tuser;
                in_eol_reg   <= s_tlast;
                in_off_reg   <= s_tdata[23:8];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg    <= phase_next;
                dcnt_reg     <= dcnt_next;
                num_reg      <= num_next;
                kind_reg     <= kind_next;
                ordered_reg  <= ordered_next;
                consumed_reg <= consumed_next;
                sp_start_reg <= sp_start_next;
                cols_reg     <= cols_next;
                blank_reg    <= blank_next;
                failed_reg   <= failed_next;
                offset_reg   <= offset_next;
            end

            if (advance && in_eol_reg)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
                out_user_reg  <= out_user_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
